[hw/rtl/zobtt_pkg.sv]
package zobtt_pkg;

   // Field widths
   localparam int FUNC_W  = 3;
   localparam int KIND_W  = 2;
   localparam int COORD_W = 4;
   localparam int EVAL_W  = 32;
   localparam int KEY32_W = 32;
   localparam int KEY64_W = 64;
   localparam int DEPTH_W = 6;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STONE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MOVE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PROBE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STORE = 3'd5;

   // Key layers
   localparam logic [KIND_W-1:0] LAYER_C0    = 2'd0;
   localparam logic [KIND_W-1:0] LAYER_C1    = 2'd1;
   localparam logic [KIND_W-1:0] LAYER_ARROW = 2'd2;
   localparam logic [KIND_W-1:0] LAYER_NONE  = 2'd3;

   // Bound types of a table entry
   localparam logic [KIND_W-1:0] BOUND_EXACT = 2'd0;
   localparam logic [KIND_W-1:0] BOUND_LOWER = 2'd1;
   localparam logic [KIND_W-1:0] BOUND_UPPER = 2'd2;

   // One transposition table entry
   typedef struct packed {
      logic                valid;
      logic [KIND_W-1:0]   bound;
      logic [DEPTH_W-1:0]  depth;
      logic [EVAL_W-1:0]   eval;
      logic [KEY64_W-1:0]  check;
   } tbl_entry_type;

endpackage

[hw/rtl/zobtt_reduce.sv]
// Index key modulo DIVISOR: multiply by the reciprocal, multiply back,
// subtract, then one compare and subtract. Three register stages.
module zobtt_reduce #(
   parameter int DIVISOR = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 dividend,
   output logic                        done,
   output logic [$clog2(DIVISOR)-1:0]  remainder
);

   localparam int REM_W = $clog2(DIVISOR);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
   localparam logic [31:0] DIV32 = 32'(DIVISOR);

   logic        s1_valid_ff, s2_valid_ff, done_ff;
   logic [31:0] s1_x_ff, s2_x_ff;
   logic [63:0] s1_prod_ff;
   logic [31:0] s2_prod_ff;
   logic [REM_W-1:0] rem_ff;

   logic [63:0] prod1_in;
   logic [31:0] prod2_in;
   logic [31:0] diff;
   logic [31:0] fixed;

   // Estimate quotient (low by at most one), multiply back, correct
   always_comb begin
      prod1_in = 64'(dividend) * 64'(RECIP);
      prod2_in = s1_prod_ff[63:32] * DIV32;
      diff     = s2_x_ff - s2_prod_ff;
      fixed    = (diff >= DIV32) ? (diff - DIV32) : diff;
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff;
      end
   end

   // Stage data
   always_ff @(posedge clock) begin
      s1_x_ff    <= dividend;
      s1_prod_ff <= prod1_in;
      s2_x_ff    <= s1_x_ff;
      s2_prod_ff <= prod2_in;
      rem_ff     <= fixed[REM_W-1:0];
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/zobrist_transposition_table_top.sv]
// Zobrist hash keeper with two transposition tables. One item is taken at a
// time; req_stall is low only while the sequencer is idle, and a finished beat
// may wait in the output register while the next item is taken. Load key and
// clear need no key read; add stone reads one key, and apply move makes three
// reads through the single port of the key memory, XORed into the keys by one
// shared XOR unit; probe and store go through the three-stage modulo unit for
// the table index, then one table memory access. After reset the block runs a
// clearing pass over all 2*TABLE_ENTRIES entries of both tables, one entry a
// cycle, and keeps req_stall high until it ends.
module zobrist_transposition_table_top #(
   parameter int GRID_SIZE     = 10,
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [zobtt_pkg::FUNC_W-1:0]         req_func,
   input  logic [zobtt_pkg::KIND_W-1:0]         req_kind,
   input  logic [zobtt_pkg::COORD_W-1:0]        req_from_row,
   input  logic [zobtt_pkg::COORD_W-1:0]        req_from_col,
   input  logic [zobtt_pkg::COORD_W-1:0]        req_to_row,
   input  logic [zobtt_pkg::COORD_W-1:0]        req_to_col,
   input  logic [zobtt_pkg::COORD_W-1:0]        req_arrow_row,
   input  logic [zobtt_pkg::COORD_W-1:0]        req_arrow_col,
   input  logic signed [zobtt_pkg::EVAL_W-1:0]  req_value_a,
   input  logic [zobtt_pkg::KEY64_W-1:0]        req_value_b,
   input  logic [zobtt_pkg::DEPTH_W-1:0]        req_depth,
   input  logic                                 req_table_no,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic signed [zobtt_pkg::EVAL_W-1:0]  rsp_value,
   output logic [zobtt_pkg::KEY32_W-1:0]        rsp_index_key
);

   localparam int SQUARES   = GRID_SIZE * GRID_SIZE;
   localparam int KEY_SLOTS = 3 * SQUARES;
   localparam int SLOT_W    = $clog2(KEY_SLOTS);
   localparam int TBL_DEPTH = 2 * TABLE_ENTRIES;
   localparam int TIDX_W    = $clog2(TBL_DEPTH);
   localparam int REM_W     = $clog2(TABLE_ENTRIES);
   localparam logic [zobtt_pkg::COORD_W:0] GRID_LIM = (zobtt_pkg::COORD_W+1)'(GRID_SIZE);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_KEY   = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_PROBE = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   // Key slot of a layer and square; only meaningful when the square is on board
   function automatic logic [SLOT_W-1:0] slot_of(
      input logic [zobtt_pkg::KIND_W-1:0]  layer,
      input logic [zobtt_pkg::COORD_W-1:0] row,
      input logic [zobtt_pkg::COORD_W-1:0] col
   );
      return SLOT_W'(layer) * SLOT_W'(SQUARES) + SLOT_W'(row) * SLOT_W'(GRID_SIZE)
             + SLOT_W'(col);
   endfunction

   function automatic logic slot_ok(
      input logic [zobtt_pkg::KIND_W-1:0]  layer,
      input logic [zobtt_pkg::COORD_W-1:0] row,
      input logic [zobtt_pkg::COORD_W-1:0] col
   );
      return (layer != zobtt_pkg::LAYER_NONE) && ({1'b0, row} < GRID_LIM)
             && ({1'b0, col} < GRID_LIM);
   endfunction

   function automatic logic [TIDX_W-1:0] req_table_no_sel(
      input logic             tno,
      input logic [REM_W-1:0] rem
   );
      return tno ? (TIDX_W'(TABLE_ENTRIES) + TIDX_W'(rem)) : TIDX_W'(rem);
   endfunction

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [TIDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]        step_ff, step_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [zobtt_pkg::KEY32_W-1:0] index_hash_ff, index_hash_in;
   logic [zobtt_pkg::KEY64_W-1:0] check_hash_ff, check_hash_in;

   // Latched request and result
   logic [zobtt_pkg::FUNC_W-1:0]  func_ff;
   logic [zobtt_pkg::KIND_W-1:0]  kind_ff;
   logic [zobtt_pkg::COORD_W-1:0] from_row_ff, from_col_ff, to_row_ff, to_col_ff;
   logic [zobtt_pkg::COORD_W-1:0] arrow_row_ff, arrow_col_ff;
   logic [zobtt_pkg::EVAL_W-1:0]  value_a_ff, beta_ff;
   logic [zobtt_pkg::DEPTH_W-1:0] depth_ff;
   logic                          table_no_ff;
   logic                          res_hit_ff, res_hit_in;
   logic [zobtt_pkg::EVAL_W-1:0]  res_value_ff, res_value_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [zobtt_pkg::EVAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [zobtt_pkg::KEY32_W-1:0] rsp_key_ff, rsp_key_in;

   // Memories
   logic [zobtt_pkg::KEY32_W+zobtt_pkg::KEY64_W-1:0] key_mem [KEY_SLOTS];
   logic [zobtt_pkg::KEY32_W+zobtt_pkg::KEY64_W-1:0] key_rdata_ff;
   zobtt_pkg::tbl_entry_type tbl_mem [TBL_DEPTH];
   zobtt_pkg::tbl_entry_type tbl_rdata_ff;

   logic                          accept;
   logic                          out_free;
   logic                          mod_start, mod_done;
   logic [REM_W-1:0]              mod_rem;
   logic [TIDX_W-1:0]             entry_idx;
   logic                          key_we, key_re;
   logic [SLOT_W-1:0]             key_waddr, key_raddr;
   logic [zobtt_pkg::KIND_W-1:0]  piece_layer, step_layer;
   logic [zobtt_pkg::COORD_W-1:0] step_row, step_col;
   logic [1:0]                    nsteps;
   logic                          tbl_we, tbl_re;
   logic [TIDX_W-1:0]             tbl_waddr;
   zobtt_pkg::tbl_entry_type      tbl_wdata;
   logic                          probe_hit;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mod_start = accept && ((req_func == zobtt_pkg::FUNC_PROBE)
                                 || (req_func == zobtt_pkg::FUNC_STORE));

   zobtt_reduce #(
      .DIVISOR (TABLE_ENTRIES)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (index_hash_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Pick the key read for the current step
   always_comb begin
      piece_layer = (func_ff != zobtt_pkg::FUNC_MOVE) ? kind_ff :
                    (kind_ff == zobtt_pkg::LAYER_C0) ? zobtt_pkg::LAYER_C0 :
                    zobtt_pkg::LAYER_C1;
      nsteps = (func_ff == zobtt_pkg::FUNC_MOVE) ? 2'd3 : 2'd1;
      case (step_ff)
         2'd0: begin
            step_layer = piece_layer;
            step_row   = from_row_ff;
            step_col   = from_col_ff;
         end
         2'd1: begin
            step_layer = piece_layer;
            step_row   = to_row_ff;
            step_col   = to_col_ff;
         end
         default: begin
            step_layer = zobtt_pkg::LAYER_ARROW;
            step_row   = arrow_row_ff;
            step_col   = arrow_col_ff;
         end
      endcase
      key_raddr = slot_of(step_layer, step_row, step_col);
      key_re    = (state_ff == ST_KEY) && (step_ff < nsteps);
      key_waddr = slot_of(req_kind, req_from_row, req_from_col);
      key_we    = accept && (req_func == zobtt_pkg::FUNC_LOAD)
                  && slot_ok(req_kind, req_from_row, req_from_col);
   end

   // Table address, write data and probe check
   always_comb begin
      entry_idx = req_table_no_sel(table_no_ff, mod_rem);
      tbl_we    = (state_ff == ST_CLEAR)
                  || ((state_ff == ST_MOD) && mod_done && (func_ff == zobtt_pkg::FUNC_STORE));
      tbl_re    = (state_ff == ST_MOD) && mod_done && (func_ff != zobtt_pkg::FUNC_STORE);
      tbl_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : entry_idx;
      tbl_wdata.valid = (state_ff != ST_CLEAR);
      tbl_wdata.bound = kind_ff;
      tbl_wdata.depth = depth_ff;
      tbl_wdata.eval  = value_a_ff;
      tbl_wdata.check = check_hash_ff;
      probe_hit = tbl_rdata_ff.valid && (tbl_rdata_ff.check == check_hash_ff)
                  && (tbl_rdata_ff.depth == depth_ff)
                  && ((tbl_rdata_ff.bound == zobtt_pkg::BOUND_EXACT)
                      || ((tbl_rdata_ff.bound == zobtt_pkg::BOUND_LOWER)
                          && ($signed(tbl_rdata_ff.eval) >= $signed(beta_ff)))
                      || ((tbl_rdata_ff.bound == zobtt_pkg::BOUND_UPPER)
                          && ($signed(value_a_ff) >= $signed(tbl_rdata_ff.eval))));
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      step_in       = step_ff;
      rd_pend_in    = 1'b0;
      index_hash_in = index_hash_ff;
      check_hash_in = check_hash_ff;
      res_hit_in    = res_hit_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_key_in    = rsp_key_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == TIDX_W'(TBL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_hit_in   = 1'b0;
               res_value_in = '0;
               step_in      = 2'd0;
               case (req_func) inside
                  zobtt_pkg::FUNC_CLEAR: begin
                     index_hash_in = '0;
                     check_hash_in = '0;
                     state_in      = ST_FIN;
                  end
                  zobtt_pkg::FUNC_STONE, zobtt_pkg::FUNC_MOVE: state_in = ST_KEY;
                  zobtt_pkg::FUNC_PROBE, zobtt_pkg::FUNC_STORE: state_in = ST_MOD;
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_KEY: begin
            // fold in the key read last cycle, issue the next one
            if (rd_pend_ff) begin
               index_hash_in = index_hash_ff ^ key_rdata_ff[zobtt_pkg::KEY64_W +: 32];
               check_hash_in = check_hash_ff ^ key_rdata_ff[zobtt_pkg::KEY64_W-1:0];
            end
            if (key_re) begin
               rd_pend_in = slot_ok(step_layer, step_row, step_col);
               step_in    = step_ff + 1'b1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = (func_ff == zobtt_pkg::FUNC_STORE) ? ST_FIN : ST_PROBE;
            end
         end
         ST_PROBE: begin
            res_hit_in   = probe_hit;
            res_value_in = probe_hit ? tbl_rdata_ff.eval : '0;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_value_in = res_value_ff;
               rsp_key_in   = index_hash_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         step_ff       <= 2'd0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         index_hash_ff <= '0;
         check_hash_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         step_ff       <= step_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         index_hash_ff <= index_hash_in;
         check_hash_ff <= check_hash_in;
      end
   end

   // Capture the request, hold results
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff      <= req_func;
         kind_ff      <= req_kind;
         from_row_ff  <= req_from_row;
         from_col_ff  <= req_from_col;
         to_row_ff    <= req_to_row;
         to_col_ff    <= req_to_col;
         arrow_row_ff <= req_arrow_row;
         arrow_col_ff <= req_arrow_col;
         value_a_ff   <= req_value_a;
         beta_ff      <= req_value_b[zobtt_pkg::EVAL_W-1:0];
         depth_ff     <= req_depth;
         table_no_ff  <= req_table_no;
      end
      res_hit_ff   <= res_hit_in;
      res_value_ff <= res_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_key_ff   <= rsp_key_in;
   end

   // Key memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= {req_value_a, req_value_b};
      end
      if (key_re) begin
         key_rdata_ff <= key_mem[key_raddr];
      end
   end

   // Table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rdata_ff <= tbl_mem[entry_idx];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_index_key = rsp_key_ff;

endmodule

[hw/rtl/zobtt_checker.sv]
module zobtt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_hit,
   input logic [zobtt_pkg::EVAL_W-1:0]        rsp_value,
   input logic [zobtt_pkg::KEY32_W-1:0]       rsp_index_key
);

   // Clearing pass keeps the input stalled right after reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not stalled after reset");

   // One item at a time: an accepted beat stalls the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in work");

   // A miss or a non-probe result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_value == '0)
      else $error("nonzero value without a hit");

   // Stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_index_key) && $stable(rsp_value))
      else $error("stalled result beat changed");

endmodule

bind zobrist_transposition_table_top zobtt_checker u_zobtt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_hit       (rsp_hit),
   .rsp_value     (rsp_value),
   .rsp_index_key (rsp_index_key)
);
